// ===== hdl/opc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opc_pkg: shared types and constants of the order-2 predictor codec
// Beat structs for both channels, table entry and request types, FSM states.
// ----------------------------------------------------------------------------
package opc_pkg;

	// prediction table geometry
	localparam int TABLE_DEPTH = 32768;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
	localparam int CTX_SHIFT   = 7;

	localparam logic [7:0] FILL_BYTE  = 8'h20;
	localparam logic [3:0] GROUP_SIZE = 4'd8;

	// epoch tag kept next to each table byte; zero marks a swept entry
	localparam int EPOCH_W = 4;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = {{(EPOCH_W-1){1'b0}}, 1'b1};
	localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

	// mode register codes
	localparam logic MODE_COMPRESS   = 1'b0;
	localparam logic MODE_DECOMPRESS = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_beat_t;

	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [7:0]         val;
	} tbl_entry_t;

	typedef struct packed {
		logic                en;
		logic                we;
		logic [TABLE_AW-1:0] addr;
		tbl_entry_t          wdata;
	} ram_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CMP,
		ST_EMIT,
		ST_PRD_RD,
		ST_PRD_WR
	} opc_state_t;

endpackage

// ===== hdl/opc_table_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opc_table_ram: prediction table storage
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module opc_table_ram
	import opc_pkg::*;
(
	input  logic       clk,
	input  ram_req_t   req,
	output tbl_entry_t rdata
);

	tbl_entry_t mem [TABLE_DEPTH];
	tbl_entry_t rdata_q;

	// write or read the addressed entry; read data holds until the next read
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata_q <= mem[req.addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/order2_predictor_codec_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order2_predictor_codec_top: order-2 predictor compressor / decompressor
// Predicts each byte from the two before it through a 32768-entry table.
// ----------------------------------------------------------------------------
// Usage:
//  - Input beats carry a data byte and a stream-end mark; output beats carry
//    a byte and a mark on the last beat caused by one input beat.
//  - cfg_we/cfg_data write the mode (0 compress, 1 decompress); the user
//    writes only while idle (not enforced); a mode change restarts the stream.
//  - Compress per byte: table read, then compare and, on a miss, write back
//    on the single RAM port. A full group or a stream end then emits the flag
//    byte and its literals, one beat per cycle unless stalled; input held off.
//  - Decompress: a flag or literal beat is handled as it is accepted; each
//    predicted byte gets a table read, then an emit, input held off meanwhile.
//  - Table reset is done by an epoch tag stored with each entry. After
//    arst_n, and after every 15th stream restart (stream end or mode
//    change), a sweep writes all 32768 entries, one per cycle; input is
//    stalled for the whole sweep.
//  - One output register decouples the receiver: while out_stall is high
//    the beat holds, and a compress byte can still be taken meanwhile.
// ----------------------------------------------------------------------------
module order2_predictor_codec_top
	import opc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_beat,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_beat
);

	opc_state_t state_q, state_d;

	logic               mode_q;
	logic [7:0]         prev_q, pprev_q;
	logic [7:0]         flag_q;
	logic [3:0]         pos_q;
	logic [3:0]         lcnt_q;
	logic               await_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic               sweep_q;
	logic [TABLE_AW-1:0] clr_addr_q;
	logic               end_q;
	logic [7:0]         cmp_byte_q;
	logic [7:0]         lit_q [8];
	logic [3:0]         emit_idx_q;
	logic [7:0]         emit_flag_q;
	logic [3:0]         emit_cnt_q;
	logic               out_valid_q;
	out_beat_t          out_beat_q;

	ram_req_t   ram_req;
	tbl_entry_t ram_rdata;

	logic [TABLE_AW-1:0] ctx_idx;
	logic [7:0] pred;
	logic       out_free, in_acc, cfg_chg;
	logic       cmp_acc, flg_acc, lit_acc, pred_ld, emit_ld, emit_last;
	logic       hit, c_done;
	logic [7:0] c_flag;
	logic [3:0] c_cnt, c_pos;
	logic [7:0] d_flag;
	logic [3:0] d_pos;
	logic       d_cont, d_wrap;
	logic       stream_rst;
	opc_state_t rst_next;

	opc_table_ram u_table (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// context index and prediction with epoch check
	assign ctx_idx = {pprev_q, {CTX_SHIFT{1'b0}}} ^ {{(TABLE_AW-8){1'b0}}, prev_q};
	assign pred    = (ram_rdata.tag == epoch_q) ? ram_rdata.val : FILL_BYTE;

	// handshake qualifiers
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) ||
	                  ((mode_q == MODE_DECOMPRESS) && !await_q && !out_free);
	assign in_acc   = in_valid && !in_stall;
	assign cfg_chg  = cfg_we && (cfg_data != mode_q);

	assign cmp_acc = in_acc && (mode_q == MODE_COMPRESS);
	assign flg_acc = in_acc && (mode_q == MODE_DECOMPRESS) && await_q;
	assign lit_acc = in_acc && (mode_q == MODE_DECOMPRESS) && !await_q;
	assign pred_ld = (state_q == ST_PRD_WR) && out_free;
	assign emit_ld = (state_q == ST_EMIT) && out_free;
	assign emit_last = (emit_idx_q == emit_cnt_q);

	// compress compare step
	assign hit    = (pred == cmp_byte_q);
	assign c_flag = hit ? (flag_q | (8'd1 << pos_q[2:0])) : flag_q;
	assign c_cnt  = (!hit && (lcnt_q < GROUP_SIZE)) ? lcnt_q + 4'd1 : lcnt_q;
	assign c_pos  = pos_q + 4'd1;
	assign c_done = (c_pos >= GROUP_SIZE) || end_q;

	// decompress bit step after an emitted byte
	assign d_flag = flag_q >> 1;
	assign d_pos  = pos_q + 4'd1;
	assign d_wrap = (d_pos >= GROUP_SIZE);
	assign d_cont = !d_wrap && d_flag[0];

	assign rst_next = (epoch_q == EPOCH_MAX) ? ST_CLEAR : ST_IDLE;

	// stream restart events
	assign stream_rst = (cfg_chg && (state_q != ST_CLEAR)) ||
	                    ((state_q == ST_CMP) && end_q) ||
	                    (flg_acc && in_beat.stream_end && !in_beat.data_byte[0]) ||
	                    (lit_acc && in_beat.stream_end && !d_cont) ||
	                    (pred_ld && end_q && !d_cont);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (&clr_addr_q) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cfg_chg) begin
					state_d = rst_next;
				end else if (cmp_acc) begin
					state_d = ST_CMP;
				end else if (flg_acc) begin
					if (in_beat.data_byte[0]) state_d = ST_PRD_RD;
					else if (in_beat.stream_end) state_d = rst_next;
				end else if (lit_acc) begin
					if (d_cont) state_d = ST_PRD_RD;
					else if (in_beat.stream_end) state_d = rst_next;
				end
			end
			ST_CMP: begin
				state_d = c_done ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (out_free && emit_last) state_d = sweep_q ? ST_CLEAR : ST_IDLE;
			end
			ST_PRD_RD: begin
				state_d = ST_PRD_WR;
			end
			ST_PRD_WR: begin
				if (out_free) begin
					if (d_cont) state_d = ST_PRD_RD;
					else if (end_q) state_d = rst_next;
					else state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// table port requests
	always_comb begin
		ram_req = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_req.en   = 1'b1;
				ram_req.we   = 1'b1;
				ram_req.addr = clr_addr_q;
			end
			ST_IDLE: begin
				ram_req.en          = cmp_acc || lit_acc;
				ram_req.we          = lit_acc;
				ram_req.addr        = ctx_idx;
				ram_req.wdata.tag   = epoch_q;
				ram_req.wdata.val   = in_beat.data_byte;
			end
			ST_CMP: begin
				ram_req.en          = !hit;
				ram_req.we          = 1'b1;
				ram_req.addr        = ctx_idx;
				ram_req.wdata.tag   = epoch_q;
				ram_req.wdata.val   = cmp_byte_q;
			end
			ST_PRD_RD: begin
				ram_req.en   = 1'b1;
				ram_req.addr = ctx_idx;
			end
			default: ram_req = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// mode, sweep and epoch control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_COMPRESS;
			clr_addr_q <= '0;
			epoch_q    <= EPOCH_FIRST;
			sweep_q    <= 1'b0;
		end else begin
			if (cfg_we) mode_q <= cfg_data;
			if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
			if ((state_q == ST_CLEAR) && (&clr_addr_q)) begin
				epoch_q <= EPOCH_FIRST;
			end else if (stream_rst && (state_q != ST_CLEAR)) begin
				epoch_q <= epoch_q + 1'b1;
			end
			if ((state_q == ST_CMP) && end_q && (epoch_q == EPOCH_MAX)) sweep_q <= 1'b1;
			else if (emit_ld && emit_last) sweep_q <= 1'b0;
		end
	end

	// stream state: context, flag, position, literal count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			pprev_q     <= '0;
			flag_q      <= '0;
			pos_q       <= '0;
			lcnt_q      <= '0;
			await_q     <= 1'b1;
			end_q       <= 1'b0;
			emit_idx_q  <= '0;
		end else begin
			if (in_acc) end_q <= in_beat.stream_end;
			if (state_q == ST_CMP) emit_idx_q <= '0;
			else if (emit_ld) emit_idx_q <= emit_idx_q + 4'd1;
			// drop context, flag, position and literal count on a restart
			if (stream_rst) begin
				prev_q  <= '0;
				pprev_q <= '0;
				flag_q  <= '0;
				pos_q   <= '0;
				lcnt_q  <= '0;
				await_q <= 1'b1;
			end else begin
				if (flg_acc) begin
					flag_q  <= in_beat.data_byte;
					pos_q   <= '0;
					await_q <= 1'b0;
				end
				if (lit_acc || pred_ld) begin
					pprev_q <= prev_q;
					prev_q  <= lit_acc ? in_beat.data_byte : pred;
					if (d_wrap) begin
						flag_q  <= '0;
						pos_q   <= '0;
						await_q <= 1'b1;
					end else begin
						flag_q <= d_flag;
						pos_q  <= d_pos;
					end
				end
				if (state_q == ST_CMP) begin
					pprev_q <= prev_q;
					prev_q  <= cmp_byte_q;
					if (c_done) begin
						flag_q <= '0;
						pos_q  <= '0;
						lcnt_q <= '0;
					end else begin
						flag_q <= c_flag;
						pos_q  <= c_pos;
						lcnt_q <= c_cnt;
					end
				end
			end
		end
	end

	// compress payload: byte under test, literals, emit snapshot
	always_ff @(posedge clk) begin
		if (cmp_acc) cmp_byte_q <= in_beat.data_byte;
		if ((state_q == ST_CMP) && !hit) lit_q[lcnt_q[2:0]] <= cmp_byte_q;
		if (state_q == ST_CMP) begin
			emit_flag_q <= c_flag;
			emit_cnt_q  <= c_cnt;
		end
	end

	// output register: load a beat or release it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (lit_acc || pred_ld || emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (lit_acc) begin
			out_beat_q.out_byte    <= in_beat.data_byte;
			out_beat_q.last_of_run <= !d_cont;
		end else if (pred_ld) begin
			out_beat_q.out_byte    <= pred;
			out_beat_q.last_of_run <= !d_cont;
		end else if (emit_ld) begin
			out_beat_q.out_byte    <= (emit_idx_q == 4'd0) ? emit_flag_q
			                          : lit_q[3'(emit_idx_q - 4'd1)];
			out_beat_q.last_of_run <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

endmodule
